// ----- rtl/core/fa_pkg.sv -----
// ----------------------------------------------------------------------------
// fa_pkg: shared types and constants for the frame allocator
// Frame count, owner width, opcodes, policy and status codes, FSM states.
// ----------------------------------------------------------------------------
package fa_pkg;

    localparam int NUM_FRAMES = 256;
    localparam int MAX_OWNERS = 26;
    localparam int AW = $clog2(NUM_FRAMES);
    localparam int CW = AW + 1;
    localparam int OW = 5;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_COMPACT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        POL_NEXT  = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_FILL  = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_RUN = 2'd1,
        ST_NO_MEM = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_WRITE,
        S_DONE
    } state_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [OW-1:0] wr_data;
    } mem_req_t;

endpackage

// ----- rtl/core/fa_owner_ram.sv -----
// ----------------------------------------------------------------------------
// fa_owner_ram: owner map storage
// One write port, one registered read port; reset sweep done by sequencer.
// ----------------------------------------------------------------------------
module fa_owner_ram
    import fa_pkg::*;
(
    input  logic            aclk,
    input  mem_req_t        req,
    output logic [OW-1:0]   rd_data
);

    logic [OW-1:0] mem [NUM_FRAMES];
    logic [OW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/fa_seq.sv -----
// ----------------------------------------------------------------------------
// fa_seq: operation sequencer
// Walks the owner map one frame per cycle: scans for runs, then writes, or makes one read-modify-write pass.
// ----------------------------------------------------------------------------
module fa_seq
    import fa_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      policy,
    input  logic            start,
    input  logic [1:0]      op,
    input  logic [OW-1:0]   owner_id,
    input  logic [8:0]      alloc_size,
    output logic            busy,
    output logic            done,
    input  logic            done_ack,
    output logic [1:0]      status,
    output logic [8:0]      frames_changed,
    output logic [8:0]      frames_free,
    output mem_req_t        req,
    input  logic [OW-1:0]   rd_data
);

    state_t state_reg, state_next;
    // address of the read issued last cycle (data valid now)
    logic [CW-1:0] rp_reg, rp_next;          // issue pointer
    logic          rv_reg, rv_next;          // read in flight
    logic [AW-1:0] ra_reg, ra_next;          // address of in-flight read
    logic [CW-1:0] wp_reg, wp_next;          // compaction write pointer
    logic [CW-1:0] free_reg, free_next;      // free frame count
    logic [AW-1:0] cur_reg, cur_next;        // next fit cursor
    logic          init_reg, init_next;      // reset clear sweep
    logic [CW-1:0] ip_reg, ip_next;
    logic [1:0]    op_reg, op_next;
    logic [OW-1:0] own_reg, own_next;
    logic [8:0]    size_reg, size_next;
    logic [AW-1:0] rs_reg, rs_next;          // current run start
    logic [CW-1:0] rl_reg, rl_next;          // current run length
    logic          fnd_reg, fnd_next;
    logic [AW-1:0] at_reg, at_next;
    logic [CW-1:0] pl_reg, pl_next;          // picked length
    logic [CW-1:0] left_reg, left_next;
    logic [1:0]    st_reg, st_next;
    logic [8:0]    chg_reg, chg_next;
    logic [CW-1:0] lim_reg, lim_next;        // scan end for both passes, all policies

    logic          fr;
    logic [CW-1:0] rl_inc;
    logic          run_end;
    logic          better;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            free_reg  <= CW'(NUM_FRAMES);
            cur_reg   <= '0;
            init_reg  <= 1'b1;
            ip_reg    <= '0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            free_reg  <= free_next;
            cur_reg   <= cur_next;
            init_reg  <= init_next;
            ip_reg    <= ip_next;
        end
        rp_reg <= rp_next;  ra_reg <= ra_next;  wp_reg <= wp_next;
        op_reg <= op_next;  own_reg <= own_next; size_reg <= size_next;
        rs_reg <= rs_next;  rl_reg <= rl_next;  fnd_reg <= fnd_next;
        at_reg <= at_next;  pl_reg <= pl_next;  left_reg <= left_next;
        st_reg <= st_next;  chg_reg <= chg_next; lim_reg <= lim_next;
    end

    assign fr     = (rd_data == '0);
    assign rl_inc = rl_reg + CW'(1);

    always_comb begin
        state_next = state_reg;
        rp_next = rp_reg; rv_next = 1'b0; ra_next = ra_reg; wp_next = wp_reg;
        free_next = free_reg; cur_next = cur_reg; init_next = init_reg;
        ip_next = ip_reg; op_next = op_reg; own_next = own_reg;
        size_next = size_reg; rs_next = rs_reg; rl_next = rl_reg;
        fnd_next = fnd_reg; at_next = at_reg; pl_next = pl_reg;
        left_next = left_reg; st_next = st_reg; chg_next = chg_reg;
        lim_next = lim_reg;
        req = '0;
        run_end = 1'b0;
        better = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (init_reg) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = ip_reg[AW-1:0];
                    ip_next     = ip_reg + CW'(1);
                    if (ip_reg == CW'(NUM_FRAMES - 1)) begin
                        init_next = 1'b0;
                    end
                end else if (start) begin
                    op_next   = op;
                    own_next  = owner_id;
                    size_next = alloc_size;
                    st_next   = ST_DONE;
                    chg_next  = '0;
                    rl_next   = '0;
                    fnd_next  = 1'b0;
                    pl_next   = '0;
                    wp_next   = '0;
                    left_next = CW'(alloc_size);
                    rp_next   = '0;
                    lim_next  = CW'(NUM_FRAMES);
                    state_next = S_DONE;
                    unique case (op_t'(op))
                        OP_ALLOC: begin
                            if (alloc_size == '0 || owner_id == '0
                                || owner_id > OW'(MAX_OWNERS)) begin
                                state_next = S_DONE;
                            end else if (CW'(alloc_size) > free_reg) begin
                                st_next = ST_NO_MEM;
                            end else if (policy == POL_FILL) begin
                                state_next = S_WRITE;
                            end else begin
                                if (policy == POL_NEXT) begin
                                    rp_next = {1'b0, cur_reg};
                                end
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (owner_id != '0) begin
                                state_next = S_WRITE;
                            end
                        end
                        OP_COMPACT: state_next = S_WRITE;
                        OP_NONE:    state_next = S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end

            // run search, one frame per cycle; S_SCAN2 is the wrapped pass
            S_SCAN, S_SCAN2: begin
                if (rp_reg < lim_reg && !(policy == POL_NEXT && fnd_reg)) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rp_reg[AW-1:0];
                    ra_next     = rp_reg[AW-1:0];
                    rv_next     = 1'b1;
                    rp_next     = rp_reg + CW'(1);
                end
                if (rv_reg) begin
                    if (fr) begin
                        if (rl_reg == '0) rs_next = ra_reg;
                        rl_next = rl_inc;
                        if (policy == POL_NEXT && !fnd_reg && rl_inc >= CW'(size_reg)) begin
                            fnd_next = 1'b1;
                            at_next  = (rl_reg == '0) ? ra_reg : rs_reg;
                        end
                    end else begin
                        run_end = 1'b1;
                        rl_next = '0;
                    end
                end
                if (run_end && policy != POL_NEXT && rl_reg >= CW'(size_reg)) begin
                    better = !fnd_reg || ((policy == POL_WORST) ?
                             (rl_reg > pl_reg) : (rl_reg < pl_reg));
                    if (better) begin
                        fnd_next = 1'b1; pl_next = rl_reg; at_next = rs_reg;
                    end
                end
                if (!rv_reg && !req.rd_en) begin
                    // pass finished; close a run that reaches the top
                    if (policy != POL_NEXT && rl_reg >= CW'(size_reg)) begin
                        better = !fnd_reg || ((policy == POL_WORST) ?
                                 (rl_reg > pl_reg) : (rl_reg < pl_reg));
                        if (better) begin
                            fnd_next = 1'b1; pl_next = rl_reg; at_next = rs_reg;
                        end
                    end
                    if (policy != POL_NEXT && rl_reg >= CW'(size_reg)
                        && better) begin
                        state_next = S_WRITE;
                    end else if (fnd_reg) begin
                        state_next = S_WRITE;
                    end else if (policy == POL_NEXT && state_reg == S_SCAN) begin
                        state_next = S_SCAN2;
                    end else begin
                        st_next = ST_NO_RUN;
                        state_next = S_DONE;
                    end
                    // placement offset and the wrapped pass both start at zero
                    rp_next = '0;
                    rl_next = '0;
                    left_next = CW'(size_reg);
                end
            end

            S_WRITE: begin
                if (op_reg == OP_ALLOC && policy != POL_FILL) begin
                    // contiguous placement
                    req.wr_en   = 1'b1;
                    req.wr_addr = at_reg + AW'(rp_reg);
                    req.wr_data = own_reg;
                    rp_next = rp_reg + CW'(1);
                    if (rp_reg + CW'(1) == CW'(size_reg)) begin
                        cur_next   = at_reg + AW'(size_reg);
                        chg_next   = size_reg;
                        free_next  = free_reg - CW'(size_reg);
                        state_next = S_DONE;
                    end
                end else begin
                    // streaming read-modify-write pass over the map
                    if (rp_reg < CW'(NUM_FRAMES)) begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = rp_reg[AW-1:0];
                        ra_next     = rp_reg[AW-1:0];
                        rv_next     = 1'b1;
                        rp_next     = rp_reg + CW'(1);
                    end
                    if (rv_reg) begin
                        priority if (op_reg == OP_ALLOC) begin
                            if (fr && left_reg != '0) begin
                                req.wr_en = 1'b1; req.wr_addr = ra_reg;
                                req.wr_data = own_reg;
                                left_next = left_reg - CW'(1);
                            end
                        end else if (op_reg == OP_FREE) begin
                            if (rd_data == own_reg) begin
                                req.wr_en = 1'b1; req.wr_addr = ra_reg;
                                chg_next = chg_reg + 9'd1;
                            end
                        end else begin
                            // compaction: write pointer always trails read
                            if (!fr) begin
                                if (wp_reg[AW-1:0] != ra_reg) begin
                                    req.wr_en = 1'b1;
                                    req.wr_addr = wp_reg[AW-1:0];
                                    req.wr_data = rd_data;
                                    chg_next = chg_reg + 9'd1;
                                end
                                wp_next = wp_reg + CW'(1);
                            end
                        end
                    end
                    if (!rv_reg && !req.rd_en) begin
                        if (op_reg == OP_ALLOC) begin
                            chg_next  = size_reg;
                            free_next = free_reg - CW'(size_reg);
                            state_next = S_DONE;
                        end else if (op_reg == OP_FREE) begin
                            free_next = free_reg + CW'(chg_reg);
                            state_next = S_DONE;
                        end else begin
                            // clear the tail above the packed frames
                            if (wp_reg < CW'(NUM_FRAMES)) begin
                                req.wr_en = 1'b1;
                                req.wr_addr = wp_reg[AW-1:0];
                                wp_next = wp_reg + CW'(1);
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                    end
                end
            end

            S_DONE: begin
                if (done_ack) state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign busy           = (state_reg != S_IDLE) || init_reg;
    assign done           = (state_reg == S_DONE);
    assign status         = st_reg;
    assign frames_changed = chg_reg;
    assign frames_free    = free_reg[8:0];

endmodule

// ----- rtl/core/frame_allocator_fit_policies_core.sv -----
// ----------------------------------------------------------------------------
// frame_allocator_fit_policies_core: contiguous frame allocator
// Owner map of 256 frames with next/best/worst fit and lowest-free fill.
// ----------------------------------------------------------------------------
// One item is handled at a time, one frame per cycle through the owner RAM
// port. After reset a clearing pass over all 256 frames runs before the first
// item is taken. Allocate with a contiguous policy scans the map (next fit may
// add a wrapped second pass) and then writes the run; lowest-free fill, free
// and compact make one read-modify-write pass, compact then clearing the tail.
// Rejected requests skip both. The result is held in an output register until taken.
module frame_allocator_fit_policies_core
    import fa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,      // fit_policy
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // op[1:0], owner_id[6:2], alloc_size[15:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // status[1:0], frames_changed[10:2], frames_free[19:11]
);

    logic [1:0]    policy_reg;
    logic          busy, done;
    logic [1:0]    status;
    logic [8:0]    changed, free_cnt;
    mem_req_t      req;
    logic [OW-1:0] rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= '0;
        end else if (cfg_valid) begin
            policy_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign m_tvalid  = done;
    assign m_tdata   = {4'd0, free_cnt, changed, status};

    fa_seq u_seq (
        .aclk, .aresetn,
        .policy(policy_reg),
        .start(s_tvalid),
        .op(s_tdata[1:0]),
        .owner_id(s_tdata[6:2]),
        .alloc_size(s_tdata[15:7]),
        .busy, .done,
        .done_ack(m_tready),
        .status,
        .frames_changed(changed),
        .frames_free(free_cnt),
        .req,
        .rd_data
    );

    fa_owner_ram u_ram (
        .aclk,
        .req,
        .rd_data
    );

endmodule

// ----- rtl/core/fa_checker.sv -----
// ----------------------------------------------------------------------------
// fa_checker: port-level checks for the frame allocator
// Watches handshakes and result fields.
// ----------------------------------------------------------------------------
module fa_checker
    import fa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // no new item while a result is pending
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("item taken with result pending");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != ST_RSVD) else $error("bad status");

    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:11] <= 9'd256) else $error("free count out of range");

    a_fail_nochange: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != ST_DONE) |-> m_tdata[10:2] == 9'd0)
        else $error("failed request changed frames");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

endmodule

bind frame_allocator_fit_policies_core fa_checker u_fa_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
